>>> hw/rtl/mse_pkg.sv
// Shared opcodes, function codes, types and helpers of the MIPS subset execute block.
package mse_pkg;

  // Default size of the data memory in bytes
  localparam int unsigned MemBytesDef = 1024;

  // Primary opcodes
  localparam logic [5:0] OP_RTYPE = 6'h00;
  localparam logic [5:0] OP_J     = 6'h02;
  localparam logic [5:0] OP_JAL   = 6'h03;
  localparam logic [5:0] OP_BEQ   = 6'h04;
  localparam logic [5:0] OP_BNE   = 6'h05;
  localparam logic [5:0] OP_BGTZ  = 6'h07;
  localparam logic [5:0] OP_ADDI  = 6'h08;
  localparam logic [5:0] OP_ADDIU = 6'h09;
  localparam logic [5:0] OP_SLTI  = 6'h0a;
  localparam logic [5:0] OP_ANDI  = 6'h0c;
  localparam logic [5:0] OP_ORI   = 6'h0d;
  localparam logic [5:0] OP_NORI  = 6'h0e;
  localparam logic [5:0] OP_LUI   = 6'h0f;
  localparam logic [5:0] OP_LB    = 6'h20;
  localparam logic [5:0] OP_LH    = 6'h21;
  localparam logic [5:0] OP_LW    = 6'h23;
  localparam logic [5:0] OP_LBU   = 6'h24;
  localparam logic [5:0] OP_LHU   = 6'h25;
  localparam logic [5:0] OP_SB    = 6'h28;
  localparam logic [5:0] OP_SH    = 6'h29;
  localparam logic [5:0] OP_SW    = 6'h2b;
  localparam logic [5:0] OP_HALT  = 6'h3f;

  // R-type function codes
  localparam logic [5:0] FN_SLL   = 6'h00;
  localparam logic [5:0] FN_SRL   = 6'h02;
  localparam logic [5:0] FN_SRA   = 6'h03;
  localparam logic [5:0] FN_JR    = 6'h08;
  localparam logic [5:0] FN_MFHI  = 6'h10;
  localparam logic [5:0] FN_MFLO  = 6'h12;
  localparam logic [5:0] FN_MULT  = 6'h18;
  localparam logic [5:0] FN_MULTU = 6'h19;
  localparam logic [5:0] FN_ADD   = 6'h20;
  localparam logic [5:0] FN_ADDU  = 6'h21;
  localparam logic [5:0] FN_SUB   = 6'h22;
  localparam logic [5:0] FN_AND   = 6'h24;
  localparam logic [5:0] FN_OR    = 6'h25;
  localparam logic [5:0] FN_XOR   = 6'h26;
  localparam logic [5:0] FN_NOR   = 6'h27;
  localparam logic [5:0] FN_NAND  = 6'h28;
  localparam logic [5:0] FN_SLT   = 6'h2a;

  // Link register of jal
  localparam logic [4:0] REG_RA = 5'd31;

  // Load flavors
  typedef enum logic [2:0] {
    LD_NONE,
    LD_W,
    LD_H,
    LD_HU,
    LD_B,
    LD_BU
  } ld_kind_e;

  // Operands handed to the execute logic
  typedef struct packed {
    logic [31:0] ins;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] hi;
    logic [31:0] lo;
    logic [31:0] pc;
  } ex_in_t;

  // Decisions coming back from the execute logic
  typedef struct packed {
    logic [31:0] npc;
    logic        wr_en;
    logic [4:0]  wr_dst;
    logic [31:0] wr_val;
    ld_kind_e    ld;
    logic [31:0] mem_addr;
    logic [2:0]  st_n;
    logic        mul_en;
    logic [63:0] prod;
    logic        illegal;
    logic        halt;
  } ex_out_t;

  // Register a given instruction may write
  function automatic logic [4:0] dest_of(logic [31:0] ins);
    logic [4:0] d;
    if (ins[31:26] == OP_RTYPE) begin
      d = ins[15:11];
    end else if (ins[31:26] == OP_JAL) begin
      d = REG_RA;
    end else begin
      d = ins[20:16];
    end
    return d;
  endfunction

endpackage

>>> hw/rtl/mips_subset_execute_top.sv
// Top level of the MIPS subset execute block: pipeline, register file, data memory.
//
// Executes one instruction word per request and returns one result per request.
// A new request is taken every clock once the clear sweep is done and while no
// result stalls. m_axis_tvalid rises once the request has passed the input
// register, which feeds operand read and execute, then the memory stage and then
// the result register. Results of back-to-back requests follow one per cycle
// while none stalls. A stalled result holds the whole pipeline. Register file
// and data memory reads are registered RAM reads, so results of earlier
// instructions reach later ones through bypass paths rather than through stalls.
// After reset the data memory is swept to zero, one row of four bytes per cycle;
// s_axis_tready stays low until the sweep is done. MemBytes must be a power of
// two. Writing start_pc also loads the program counter.
module mips_subset_execute_top
  import mse_pkg::*;
#(
  parameter int unsigned MemBytes = MemBytesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,     // start_pc
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,    // [31:0] instruction
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [31:0] next_pc, [63:32] changed_regs, [64] hi_changed, [65] lo_changed,
  // [66] halted, [67] illegal, [71:68] zero
  output logic [71:0] m_axis_tdata
);

  localparam int unsigned Rows = MemBytes / 4;
  localparam int unsigned RowW = $clog2(Rows);

  // Pipeline control
  logic en;
  logic acc;

  // Architectural state
  logic [31:0] pc_q;
  logic [31:0] hi_q;
  logic [31:0] lo_q;
  logic        halt_q;
  logic [31:0] rf_vld_q;

  // Memory clear sweep
  logic            clr_act_q;
  logic [RowW-1:0] clr_cnt_q;

  // Stage 1: instruction and operand read
  logic        s1_vld_q;
  logic [31:0] s1_ins_q;

  // Stage 2: memory access
  logic            s2_vld_q;
  logic [31:0]     s2_npc_q;
  logic            s2_wen_q;
  logic [4:0]      s2_dst_q;
  logic [31:0]     s2_val_q;
  logic [31:0]     s2_old_q;
  ld_kind_e        s2_ld_q;
  logic [1:0]      s2_off_q;
  logic [RowW-1:0] s2_row_q [4];
  logic            s2_mul_q;
  logic [63:0]     s2_prod_q;
  logic            s2_ill_q;
  logic            s2_halt_q;

  // Last register file write, for reads that collided with it
  logic        lw_vld_q;
  logic [4:0]  lw_dst_q;
  logic [31:0] lw_val_q;

  // Result register
  logic        out_vld_q;
  logic [71:0] out_data_q;

  // Register file ports
  logic [4:0]  rd_rs;
  logic [4:0]  rd_rt;
  logic [4:0]  rd_od;
  logic [31:0] rf_rs_data;
  logic [31:0] rf_rt_data;
  logic [31:0] rf_od_data;

  // Execute
  ex_in_t      ex_in;
  ex_out_t     ex_out;
  logic [31:0] s1_old;
  logic        s1_go;

  // Data memory banks
  logic [1:0]      st_off;
  logic [RowW-1:0] st_base;
  logic [RowW-1:0] bk_row   [4];
  logic            bk_hit   [4];
  logic [7:0]      bk_byte  [4];
  logic            bk_we    [4];
  logic [RowW-1:0] bk_waddr [4];
  logic [7:0]      bk_wdata [4];
  logic [RowW-1:0] bk_raddr [4];
  logic [7:0]      bk_rdata [4];

  // Stage 2 results
  logic [7:0]  ld_b0;
  logic [7:0]  ld_b1;
  logic [7:0]  ld_b2;
  logic [7:0]  ld_b3;
  logic [31:0] ld_val;
  logic [31:0] s2_fin;
  logic        s2_wact;
  logic [31:0] s2_mask;
  logic [31:0] hi_fwd;
  logic [31:0] lo_fwd;

  // Advance the whole pipeline when the result register can take a value
  assign en            = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en && !clr_act_q;
  assign acc           = s_axis_tvalid && s_axis_tready;

  // Resolve a register read against writes the RAM has not yet shown
  function automatic logic [31:0] fwd(
    logic [4:0] r, logic [31:0] ram, logic s2w, logic [4:0] s2d, logic [31:0] s2v,
    logic lww, logic [4:0] lwd, logic [31:0] lwv, logic vb
  );
    logic [31:0] v;
    if (r == 5'd0) begin
      v = 32'd0;
    end else if (s2w && (s2d == r)) begin
      v = s2v;
    end else if (lww && (lwd == r)) begin
      v = lwv;
    end else if (vb) begin
      v = ram;
    end else begin
      v = 32'd0;
    end
    return v;
  endfunction

  // Read operands for the incoming request, or re-read for the held one
  assign rd_rs = en ? s_axis_tdata[25:21] : s1_ins_q[25:21];
  assign rd_rt = en ? s_axis_tdata[20:16] : s1_ins_q[20:16];
  assign rd_od = en ? dest_of(s_axis_tdata) : dest_of(s1_ins_q);

  mse_ram #(.Width(32), .Depth(32)) u_rf_rs (
    .clk_i  (clk_i),
    .we_i   (en && s2_wact),
    .waddr_i(s2_dst_q),
    .wdata_i(s2_fin),
    .raddr_i(rd_rs),
    .rdata_o(rf_rs_data)
  );

  mse_ram #(.Width(32), .Depth(32)) u_rf_rt (
    .clk_i  (clk_i),
    .we_i   (en && s2_wact),
    .waddr_i(s2_dst_q),
    .wdata_i(s2_fin),
    .raddr_i(rd_rt),
    .rdata_o(rf_rt_data)
  );

  mse_ram #(.Width(32), .Depth(32)) u_rf_od (
    .clk_i  (clk_i),
    .we_i   (en && s2_wact),
    .waddr_i(s2_dst_q),
    .wdata_i(s2_fin),
    .raddr_i(rd_od),
    .rdata_o(rf_od_data)
  );

  // Bypass HI and LO from a multiply one stage ahead
  assign hi_fwd = (s2_vld_q && s2_mul_q) ? s2_prod_q[63:32] : hi_q;
  assign lo_fwd = (s2_vld_q && s2_mul_q) ? s2_prod_q[31:0] : lo_q;

  // Assemble execute operands
  always_comb begin
    ex_in.ins = s1_ins_q;
    ex_in.a   = fwd(s1_ins_q[25:21], rf_rs_data, s2_wact, s2_dst_q, s2_fin,
                    lw_vld_q, lw_dst_q, lw_val_q, rf_vld_q[s1_ins_q[25:21]]);
    ex_in.b   = fwd(s1_ins_q[20:16], rf_rt_data, s2_wact, s2_dst_q, s2_fin,
                    lw_vld_q, lw_dst_q, lw_val_q, rf_vld_q[s1_ins_q[20:16]]);
    ex_in.hi  = hi_fwd;
    ex_in.lo  = lo_fwd;
    ex_in.pc  = pc_q;
    s1_old    = fwd(dest_of(s1_ins_q), rf_od_data, s2_wact, s2_dst_q, s2_fin,
                    lw_vld_q, lw_dst_q, lw_val_q, rf_vld_q[dest_of(s1_ins_q)]);
  end

  mse_exec u_exec (
    .ex_i(ex_in),
    .ex_o(ex_out)
  );

  // Stage 1 item that really executes
  assign s1_go = en && s1_vld_q && !halt_q;

  // Spread a memory access over the four byte banks, big-endian
  assign st_off  = ex_out.mem_addr[1:0];
  assign st_base = ex_out.mem_addr[RowW+1:2];

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      logic [1:0] k;
      logic [2:0] idx;
      k          = 2'(j) - st_off;
      idx        = ex_out.st_n - {1'b0, k} - 3'd1;
      bk_row[j]  = st_base + RowW'(2'(j) < st_off);
      bk_hit[j]  = ({1'b0, k} < ex_out.st_n);
      bk_byte[j] = 8'(ex_in.b >> {idx[1:0], 3'b000});
      bk_we[j]   = clr_act_q || (s1_go && bk_hit[j]);
      bk_waddr[j] = clr_act_q ? clr_cnt_q : bk_row[j];
      bk_wdata[j] = clr_act_q ? 8'h00 : bk_byte[j];
      bk_raddr[j] = en ? bk_row[j] : s2_row_q[j];
    end
  end

  for (genvar g = 0; g < 4; g++) begin : g_bank
    mse_ram #(.Width(8), .Depth(Rows)) u_bank (
      .clk_i  (clk_i),
      .we_i   (bk_we[g]),
      .waddr_i(bk_waddr[g]),
      .wdata_i(bk_wdata[g]),
      .raddr_i(bk_raddr[g]),
      .rdata_o(bk_rdata[g])
    );
  end

  // Gather loaded bytes in address order
  assign ld_b0 = bk_rdata[s2_off_q];
  assign ld_b1 = bk_rdata[2'(s2_off_q + 2'd1)];
  assign ld_b2 = bk_rdata[2'(s2_off_q + 2'd2)];
  assign ld_b3 = bk_rdata[2'(s2_off_q + 2'd3)];

  always_comb begin
    case (s2_ld_q)
      LD_W:    ld_val = {ld_b0, ld_b1, ld_b2, ld_b3};
      LD_H:    ld_val = {{16{ld_b0[7]}}, ld_b0, ld_b1};
      LD_HU:   ld_val = {16'h0000, ld_b0, ld_b1};
      LD_B:    ld_val = {{24{ld_b0[7]}}, ld_b0};
      LD_BU:   ld_val = {24'h000000, ld_b0};
      default: ld_val = 32'd0;
    endcase
  end

  assign s2_fin  = (s2_ld_q == LD_NONE) ? s2_val_q : ld_val;
  assign s2_wact = s2_vld_q && s2_wen_q;
  assign s2_mask = (s2_wact && (s2_fin != s2_old_q)) ? (32'd1 << s2_dst_q) : 32'd0;

  // Clear sweep over the data memory after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_act_q <= 1'b1;
      clr_cnt_q <= '0;
    end else if (clr_act_q) begin
      clr_cnt_q <= clr_cnt_q + RowW'(1);
      if (clr_cnt_q == RowW'(Rows - 1)) begin
        clr_act_q <= 1'b0;
      end
    end
  end

  // Architectural state updates
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q     <= '0;
      hi_q     <= '0;
      lo_q     <= '0;
      halt_q   <= 1'b0;
      rf_vld_q <= '0;
      lw_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        pc_q <= cfg_wdata_i;
      end else if (s1_go) begin
        pc_q <= ex_out.npc;
      end
      if (s1_go && ex_out.halt) begin
        halt_q <= 1'b1;
      end
      if (en) begin
        lw_vld_q <= s2_wact;
        if (s2_wact) begin
          rf_vld_q[s2_dst_q] <= 1'b1;
        end
        if (s2_vld_q && s2_mul_q) begin
          hi_q <= s2_prod_q[63:32];
          lo_q <= s2_prod_q[31:0];
        end
      end
    end
  end

  // Capture the last register file write
  always_ff @(posedge clk_i) begin
    if (en) begin
      lw_dst_q <= s2_dst_q;
      lw_val_q <= s2_fin;
    end
  end

  // Pipeline valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q  <= acc;
      s2_vld_q  <= s1_vld_q;
      out_vld_q <= s2_vld_q;
    end
  end

  // Pipeline payload; an item seen while halted has no effect
  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_ins_q  <= s_axis_tdata;
      s2_npc_q  <= halt_q ? pc_q : ex_out.npc;
      s2_wen_q  <= !halt_q && ex_out.wr_en;
      s2_dst_q  <= ex_out.wr_dst;
      s2_val_q  <= ex_out.wr_val;
      s2_old_q  <= s1_old;
      s2_ld_q   <= ex_out.ld;
      s2_off_q  <= st_off;
      s2_row_q  <= bk_row;
      s2_mul_q  <= !halt_q && ex_out.mul_en;
      s2_prod_q <= ex_out.prod;
      s2_ill_q  <= !halt_q && ex_out.illegal;
      s2_halt_q <= halt_q || ex_out.halt;
      out_data_q <= {4'h0, s2_ill_q, s2_halt_q,
                     s2_mul_q && (s2_prod_q[31:0] != lo_q),
                     s2_mul_q && (s2_prod_q[63:32] != hi_q),
                     s2_mask, s2_npc_q};
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

endmodule

>>> hw/rtl/mse_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mse_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write, and read the old contents on a collision
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/mse_exec.sv
// Instruction decode, ALU, multiplier and next-PC logic of one instruction.
module mse_exec
  import mse_pkg::*;
(
  input  ex_in_t  ex_i,
  output ex_out_t ex_o
);

  logic [5:0]  op;
  logic [5:0]  fn;
  logic [4:0]  sh;
  logic [31:0] simm;
  logic [31:0] zimm;
  logic [31:0] pc4;
  logic [31:0] br_tgt;
  logic        sgn;
  logic [65:0] prod_full;

  assign op     = ex_i.ins[31:26];
  assign fn     = ex_i.ins[5:0];
  assign sh     = ex_i.ins[10:6];
  assign simm   = {{16{ex_i.ins[15]}}, ex_i.ins[15:0]};
  assign zimm   = {16'h0000, ex_i.ins[15:0]};
  assign pc4    = ex_i.pc + 32'd4;
  assign br_tgt = pc4 + {simm[29:0], 2'b00};

  // Signed or unsigned 32x32 product through one 33x33 signed multiply
  assign sgn       = (fn == FN_MULT);
  assign prod_full = $signed({sgn & ex_i.a[31], ex_i.a}) *
                     $signed({sgn & ex_i.b[31], ex_i.b});

  always_comb begin
    ex_o          = '0;
    ex_o.npc      = pc4;
    ex_o.wr_dst   = dest_of(ex_i.ins);
    ex_o.ld       = LD_NONE;
    ex_o.mem_addr = ex_i.a + simm;
    ex_o.prod     = prod_full[63:0];

    case (op)
      OP_RTYPE: begin
        ex_o.wr_en = 1'b1;
        case (fn)
          FN_ADD, FN_ADDU: ex_o.wr_val = ex_i.a + ex_i.b;
          FN_SUB:   ex_o.wr_val = ex_i.a - ex_i.b;
          FN_AND:   ex_o.wr_val = ex_i.a & ex_i.b;
          FN_OR:    ex_o.wr_val = ex_i.a | ex_i.b;
          FN_XOR:   ex_o.wr_val = ex_i.a ^ ex_i.b;
          FN_NOR:   ex_o.wr_val = ~(ex_i.a | ex_i.b);
          FN_NAND:  ex_o.wr_val = ~(ex_i.a & ex_i.b);
          FN_SLT:   ex_o.wr_val = {31'd0, $signed(ex_i.a) < $signed(ex_i.b)};
          FN_SLL:   ex_o.wr_val = ex_i.b << sh;
          FN_SRL:   ex_o.wr_val = ex_i.b >> sh;
          FN_SRA:   ex_o.wr_val = $signed(ex_i.b) >>> sh;
          FN_MFHI:  ex_o.wr_val = ex_i.hi;
          FN_MFLO:  ex_o.wr_val = ex_i.lo;
          FN_JR: begin
            ex_o.wr_en = 1'b0;
            ex_o.npc   = ex_i.a;
          end
          FN_MULT, FN_MULTU: begin
            ex_o.wr_en  = 1'b0;
            ex_o.mul_en = 1'b1;
          end
          default: begin
            ex_o.wr_en   = 1'b0;
            ex_o.illegal = 1'b1;
          end
        endcase
      end
      OP_ADDI, OP_ADDIU: begin
        ex_o.wr_en  = 1'b1;
        ex_o.wr_val = ex_i.a + simm;
      end
      OP_ANDI: begin
        ex_o.wr_en  = 1'b1;
        ex_o.wr_val = ex_i.a & zimm;
      end
      OP_ORI: begin
        ex_o.wr_en  = 1'b1;
        ex_o.wr_val = ex_i.a | zimm;
      end
      OP_NORI: begin
        ex_o.wr_en  = 1'b1;
        ex_o.wr_val = ~(ex_i.a | zimm);
      end
      OP_SLTI: begin
        ex_o.wr_en  = 1'b1;
        ex_o.wr_val = {31'd0, $signed(ex_i.a) < $signed(simm)};
      end
      OP_LUI: begin
        ex_o.wr_en  = 1'b1;
        ex_o.wr_val = {ex_i.ins[15:0], 16'h0000};
      end
      OP_LW: begin
        ex_o.wr_en = 1'b1;
        ex_o.ld    = LD_W;
      end
      OP_LH: begin
        ex_o.wr_en = 1'b1;
        ex_o.ld    = LD_H;
      end
      OP_LHU: begin
        ex_o.wr_en = 1'b1;
        ex_o.ld    = LD_HU;
      end
      OP_LB: begin
        ex_o.wr_en = 1'b1;
        ex_o.ld    = LD_B;
      end
      OP_LBU: begin
        ex_o.wr_en = 1'b1;
        ex_o.ld    = LD_BU;
      end
      OP_SW: ex_o.st_n = 3'd4;
      OP_SH: ex_o.st_n = 3'd2;
      OP_SB: ex_o.st_n = 3'd1;
      OP_BEQ: begin
        if (ex_i.a == ex_i.b) begin
          ex_o.npc = br_tgt;
        end
      end
      OP_BNE: begin
        if (ex_i.a != ex_i.b) begin
          ex_o.npc = br_tgt;
        end
      end
      OP_BGTZ: begin
        if ((ex_i.a != 32'd0) && !ex_i.a[31]) begin
          ex_o.npc = br_tgt;
        end
      end
      OP_J: ex_o.npc = {pc4[31:28], ex_i.ins[25:0], 2'b00};
      OP_JAL: begin
        ex_o.wr_en  = 1'b1;
        ex_o.wr_val = pc4;
        ex_o.npc    = {pc4[31:28], ex_i.ins[25:0], 2'b00};
      end
      OP_HALT: ex_o.halt = 1'b1;
      default: ex_o.illegal = 1'b1;
    endcase

    // Drop writes to register zero
    if (ex_o.wr_dst == 5'd0) begin
      ex_o.wr_en = 1'b0;
    end
  end

endmodule

>>> hw/rtl/mse_chk.sv
// Port-level checker of the MIPS subset execute block, bound to the top level.
module mse_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [71:0] m_axis_tdata
);

  logic out_acc;
  logic seen_halt_q;

  assign out_acc = m_axis_tvalid && m_axis_tready;

  // Track whether a halted result has gone out
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_halt_q <= 1'b0;
    end else if (out_acc && m_axis_tdata[66]) begin
      seen_halt_q <= 1'b1;
    end
  end

  // Stalled result stays offered and unchanged
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped or changed while stalled");

  // Once halted, every later result is halted and has no effect
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && seen_halt_q |->
      m_axis_tdata[66] && (m_axis_tdata[63:32] == 32'd0) && !m_axis_tdata[67] &&
      !m_axis_tdata[64] && !m_axis_tdata[65])
    else $error("activity after halt");

  // An illegal instruction changes nothing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && m_axis_tdata[67] |->
      (m_axis_tdata[63:32] == 32'd0) && !m_axis_tdata[64] && !m_axis_tdata[65])
    else $error("illegal instruction changed state");

  // Register zero never changes and pad bits stay zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |-> !m_axis_tdata[32] && (m_axis_tdata[71:68] == 4'h0))
    else $error("register zero changed or pad bits set");

endmodule

bind mips_subset_execute_top mse_chk u_mse_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);

>>> tb/mips_subset_execute_top_tb.sv
// Self-checking testbench of the MIPS subset execute block with a behavioral predictor.
module mips_subset_execute_top_tb;
  import mse_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MemBytes = 1024;
  localparam int unsigned CycleLimit = 400000;

  // Opcode outside the supported set
  localparam logic [5:0] OP_UNUSED = 6'h3d;

  typedef struct packed {
    logic        illegal;
    logic        halted;
    logic        lo_changed;
    logic        hi_changed;
    logic [31:0] changed_regs;
    logic [31:0] next_pc;
  } exec_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [31:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;

  mips_subset_execute_top #(.MemBytes(MemBytes)) DUT (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Architectural state of the predicted machine
  logic [31:0] arch_regs [32];
  logic [31:0] arch_hi, arch_lo, arch_pc;
  logic [7:0]  arch_mem [MemBytes];
  logic        arch_halted;
  exec_result_t pending_results[$];
  int          error_count = 0;
  int          cycle_count = 0;
  int          hold_off_cycles = 0;
  bit          sender_bursty = 1'b1;
  bit          receiver_stalls = 1'b1;

  function automatic logic [31:0] mem_load(logic [31:0] addr, int n);
    logic [31:0] v;
    v = '0;
    for (int i = 0; i < n; i++) v = (v << 8) | arch_mem[(addr + i) % MemBytes];
    return v;
  endfunction

  function automatic void mem_store(logic [31:0] addr, int n, logic [31:0] v);
    for (int i = 0; i < n; i++) arch_mem[(addr + i) % MemBytes] = 8'(v >> (8 * (n - 1 - i)));
  endfunction

  function automatic void reg_write(logic [4:0] r, logic [31:0] v, ref logic [31:0] mask);
    if (r == 0) return;
    if (arch_regs[r] != v) mask[r] = 1'b1;
    arch_regs[r] = v;
  endfunction

  // Execute one instruction on the predicted machine
  function automatic exec_result_t execute_instr(logic [31:0] ins);
    exec_result_t res;
    logic [5:0]  op, fn;
    logic [4:0]  rs, rt, rd, sh;
    logic [31:0] imm, simm, a, b, pc4, npc, mask, old_hi, old_lo, v;
    logic [63:0] p;
    logic        bad;
    res = '0;
    if (arch_halted) begin
      res.next_pc = arch_pc;
      res.halted = 1'b1;
      return res;
    end
    op = ins[31:26]; rs = ins[25:21]; rt = ins[20:16]; rd = ins[15:11];
    sh = ins[10:6]; fn = ins[5:0];
    imm = {16'h0, ins[15:0]};
    simm = {{16{ins[15]}}, ins[15:0]};
    arch_regs[0] = '0;
    a = arch_regs[rs]; b = arch_regs[rt];
    pc4 = arch_pc + 4; npc = pc4; mask = '0; bad = 1'b0;
    old_hi = arch_hi; old_lo = arch_lo;
    case (op)
      OP_RTYPE: begin
        case (fn)
          FN_ADD, FN_ADDU: reg_write(rd, a + b, mask);
          FN_SUB: reg_write(rd, a - b, mask);
          FN_AND: reg_write(rd, a & b, mask);
          FN_OR: reg_write(rd, a | b, mask);
          FN_XOR: reg_write(rd, a ^ b, mask);
          FN_NOR: reg_write(rd, ~(a | b), mask);
          FN_NAND: reg_write(rd, ~(a & b), mask);
          FN_SLT: reg_write(rd, {31'h0, $signed(a) < $signed(b)}, mask);
          FN_SLL: reg_write(rd, b << sh, mask);
          FN_SRL: reg_write(rd, b >> sh, mask);
          FN_SRA: reg_write(rd, $signed(b) >>> sh, mask);
          FN_JR: npc = a;
          FN_MULT: begin
            p = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
            {arch_hi, arch_lo} = p;
          end
          FN_MULTU: begin
            p = {32'h0, a} * {32'h0, b};
            {arch_hi, arch_lo} = p;
          end
          FN_MFHI: reg_write(rd, arch_hi, mask);
          FN_MFLO: reg_write(rd, arch_lo, mask);
          default: bad = 1'b1;
        endcase
      end
      OP_ADDI, OP_ADDIU: reg_write(rt, a + simm, mask);
      OP_ANDI: reg_write(rt, a & imm, mask);
      OP_ORI: reg_write(rt, a | imm, mask);
      OP_NORI: reg_write(rt, ~(a | imm), mask);
      OP_SLTI: reg_write(rt, {31'h0, $signed(a) < $signed(simm)}, mask);
      OP_LUI: reg_write(rt, imm << 16, mask);
      OP_LW: reg_write(rt, mem_load(a + simm, 4), mask);
      OP_LH: begin
        v = mem_load(a + simm, 2);
        reg_write(rt, {{16{v[15]}}, v[15:0]}, mask);
      end
      OP_LHU: reg_write(rt, mem_load(a + simm, 2), mask);
      OP_LB: begin
        v = mem_load(a + simm, 1);
        reg_write(rt, {{24{v[7]}}, v[7:0]}, mask);
      end
      OP_LBU: reg_write(rt, mem_load(a + simm, 1), mask);
      OP_SW: mem_store(a + simm, 4, b);
      OP_SH: mem_store(a + simm, 2, b);
      OP_SB: mem_store(a + simm, 1, b);
      OP_BEQ: if (a == b) npc = pc4 + (simm << 2);
      OP_BNE: if (a != b) npc = pc4 + (simm << 2);
      OP_BGTZ: if (a != 0 && !a[31]) npc = pc4 + (simm << 2);
      OP_J: npc = {pc4[31:28], ins[25:0], 2'b00};
      OP_JAL: begin
        reg_write(REG_RA, pc4, mask);
        npc = {pc4[31:28], ins[25:0], 2'b00};
      end
      OP_HALT: arch_halted = 1'b1;
      default: bad = 1'b1;
    endcase
    arch_pc = npc;
    res.next_pc = npc;
    res.changed_regs = mask;
    res.hi_changed = arch_hi != old_hi;
    res.lo_changed = arch_lo != old_lo;
    res.halted = arch_halted;
    res.illegal = bad;
    return res;
  endfunction

  // Offer one request, predict its result on acceptance
  task automatic send_instr(logic [31:0] ins);
    if (sender_bursty && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ins;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.push_back(execute_instr(ins));
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Load start_pc while the block is idle
  task automatic write_start_pc(logic [31:0] pc);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= pc;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    arch_pc = pc;
  endtask

  function automatic logic [31:0] r_instr(logic [5:0] fn, logic [4:0] rs, logic [4:0] rt,
                                          logic [4:0] rd, logic [4:0] sh);
    return {OP_RTYPE, rs, rt, rd, sh, fn};
  endfunction

  function automatic logic [31:0] i_instr(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
                                          logic [15:0] imm);
    return {op, rs, rt, imm};
  endfunction

  // Random instruction, mostly legal, biased to small registers and nearby memory
  function automatic logic [31:0] random_instr();
    logic [5:0] ops[22];
    logic [5:0] fns[17];
    logic [4:0] rs, rt, rd;
    logic [15:0] imm;
    logic [31:0] raw;
    ops = '{OP_RTYPE, OP_RTYPE, OP_RTYPE, OP_J, OP_JAL, OP_BEQ, OP_BNE, OP_BGTZ, OP_ADDI,
            OP_ADDIU, OP_SLTI, OP_ANDI, OP_ORI, OP_NORI, OP_LUI, OP_LB, OP_LH, OP_LW,
            OP_LBU, OP_LHU, OP_SB, OP_SW};
    fns = '{FN_SLL, FN_SRL, FN_SRA, FN_JR, FN_MFHI, FN_MFLO, FN_MULT, FN_MULTU, FN_ADD,
            FN_ADDU, FN_SUB, FN_AND, FN_OR, FN_XOR, FN_NOR, FN_NAND, FN_SLT};
    if ($urandom_range(0, 19) == 0) begin
      // Keep raw random words from halting the machine early
      raw = $urandom();
      if (raw[31:26] == OP_HALT) raw[31:26] = OP_UNUSED;
      return raw;
    end
    if ($urandom_range(0, 1) == 0) begin
      rs = 5'($urandom_range(0, 7));
      rt = 5'($urandom_range(0, 7));
      rd = 5'($urandom_range(0, 7));
    end else begin
      rs = 5'($urandom()); rt = 5'($urandom()); rd = 5'($urandom());
    end
    imm = ($urandom_range(0, 2) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 64) - 32);
    if ($urandom_range(0, 1) == 0)
      return r_instr(fns[$urandom_range(0, 16)], rs, rt, rd, 5'($urandom()));
    if ($urandom_range(0, 40) == 0) return {OP_SH, rs, rt, imm};
    return {ops[$urandom_range(1, 21)], rs, rt, imm};
  endfunction

  task automatic test_directed_ops();
    write_start_pc(32'hFFFF_FFF8);
    send_instr(i_instr(OP_LUI, 0, 1, 16'hFFFF));
    send_instr(i_instr(OP_ORI, 1, 1, 16'hFFFF));
    send_instr(i_instr(OP_ADDI, 0, 2, 16'h8000));
    send_instr(i_instr(OP_ADDIU, 0, 3, 16'h7FFF));
    send_instr(i_instr(OP_ANDI, 1, 4, 16'hA5A5));
    send_instr(i_instr(OP_NORI, 0, 5, 16'h0000));
    send_instr(i_instr(OP_SLTI, 2, 6, 16'h0001));
    send_instr(r_instr(FN_ADD, 1, 1, 7, 0));
    send_instr(r_instr(FN_SUB, 0, 1, 8, 0));
    send_instr(r_instr(FN_NAND, 1, 4, 9, 0));
    send_instr(r_instr(FN_SRA, 0, 2, 10, 31));
    send_instr(r_instr(FN_SLL, 0, 1, 11, 31));
    send_instr(r_instr(FN_SRL, 0, 1, 12, 31));
    send_instr(r_instr(FN_MULT, 1, 2, 0, 0));
    send_instr(r_instr(FN_MULTU, 1, 1, 0, 0));
    send_instr(r_instr(FN_MFHI, 0, 0, 13, 0));
    send_instr(r_instr(FN_MFLO, 0, 0, 0, 0));
    send_instr(i_instr(OP_SW, 0, 1, 16'hFFFE));
    send_instr(i_instr(OP_SH, 0, 2, 16'h0003));
    send_instr(i_instr(OP_LB, 0, 14, 16'hFFFF));
    send_instr(i_instr(OP_LHU, 0, 15, 16'h0002));
    send_instr(i_instr(OP_LW, 0, 16, 16'h03FE));
    send_instr(i_instr(OP_BGTZ, 3, 0, 16'h8000));
    send_instr({OP_JAL, 26'h3FF_FFFF});
    send_instr({OP_UNUSED, 26'h0});
  endtask

  task automatic test_halt();
    send_instr({OP_HALT, 26'h155_5555});
    repeat (3) send_instr($urandom());
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++) send_instr(random_instr());
  endtask

  task automatic test_backpressure();
    hold_off_cycles = 60;
    receiver_stalls = 1'b1;
    test_random(30);
    drain_results();
  endtask

  // Hold off, then stall in a pattern of short random runs if receiver_stalls is set
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      m_axis_tready <= 1'b0;
    end else if (receiver_stalls) begin
      m_axis_tready <= ($urandom_range(0, 3) != 0);
    end else begin
      m_axis_tready <= 1'b1;
    end
    if (cycle_count > CycleLimit) begin
      $display("[mips_subset_execute_top] ERROR");
      $finish;
    end
  end

  // Compare each accepted result with the oldest prediction
  always @(posedge clk_i) begin
    exec_result_t want, got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[67:0];
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (got.next_pc !== want.next_pc)
          $display("%0t: next_pc exp %h got %h", $time, want.next_pc, got.next_pc);
        if (got.changed_regs !== want.changed_regs)
          $display("%0t: changed_regs exp %h got %h", $time, want.changed_regs,
                   got.changed_regs);
        if (got.hi_changed !== want.hi_changed)
          $display("%0t: hi_changed exp %b got %b", $time, want.hi_changed, got.hi_changed);
        if (got.lo_changed !== want.lo_changed)
          $display("%0t: lo_changed exp %b got %b", $time, want.lo_changed, got.lo_changed);
        if (got.halted !== want.halted)
          $display("%0t: halted exp %b got %b", $time, want.halted, got.halted);
        if (got.illegal !== want.illegal)
          $display("%0t: illegal exp %b got %b", $time, want.illegal, got.illegal);
        if (got !== want) error_count++;
      end
    end
  end

  initial begin
    foreach (arch_regs[i]) arch_regs[i] = '0;
    foreach (arch_mem[i]) arch_mem[i] = '0;
    arch_hi = '0; arch_lo = '0; arch_pc = '0; arch_halted = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed_ops();
    write_start_pc(32'h0000_1000);
    test_random(300);
    test_backpressure();
    sender_bursty = 1'b0;
    receiver_stalls = 1'b0;
    write_start_pc(32'h8000_0000);
    test_random(150);
    sender_bursty = 1'b1;
    receiver_stalls = 1'b1;
    write_start_pc(32'h0000_0000);
    test_random(220);
    test_halt();
    drain_results();
    if (error_count == 0) begin
      $display("[mips_subset_execute_top] OK");
    end else begin
      $display("[mips_subset_execute_top] ERROR");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/mse_pkg.sv
hw/rtl/mse_ram.sv
hw/rtl/mse_exec.sv
hw/rtl/mips_subset_execute_top.sv
hw/rtl/mse_chk.sv
tb/mips_subset_execute_top_tb.sv
